// File: rtl/core/ikf_pkg.sv
package ikf_pkg;

  localparam int DATA_W    = 48;
  localparam int IN_W      = 16;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_GAIN  = 3'd4;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] fx_t;

  // operation codes of the shared unit
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    fx_t     a;
    fx_t     b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    fx_t  res;
  } alu_rsp_t;

  // saturate a 50-bit sum or difference to 48 bits
  function automatic fx_t sat_sum(input logic signed [DATA_W+1:0] v);
    fx_t r;
    if (v > $signed({{2{SAT_MAX[DATA_W-1]}}, SAT_MAX})) r = SAT_MAX;
    else if (v < $signed({{2{SAT_MIN[DATA_W-1]}}, SAT_MIN})) r = SAT_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [DATA_W+1:0] s;
    s = {{2{a[DATA_W-1]}}, a} + {{2{b[DATA_W-1]}}, b};
    return sat_sum(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [DATA_W+1:0] s;
    s = {{2{a[DATA_W-1]}}, a} - {{2{b[DATA_W-1]}}, b};
    return sat_sum(s);
  endfunction

endpackage

// File: rtl/core/ikf_if.sv
interface ikf_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ikf_pkg::IN_W-1:0] angle_meas;
  logic signed [ikf_pkg::IN_W-1:0] rate_meas;
  modport source (output valid, angle_meas, rate_meas, input ready);
  modport sink   (input valid, angle_meas, rate_meas, output ready);
endinterface

interface ikf_out_if;
  logic              valid;
  logic              ready;
  ikf_pkg::fx_t      angle_est;
  ikf_pkg::fx_t      rate_est;
  modport source (output valid, angle_est, rate_est, input ready);
  modport sink   (input valid, angle_est, rate_est, output ready);
endinterface

// File: rtl/core/ikf_alu.sv
// shared unit: serial multiply (radix 2, 48 steps) with rounding, or restoring divide
module ikf_alu #(
  parameter int FRAC_BITS = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ikf_pkg::alu_req_t req,
  output ikf_pkg::alu_rsp_t rsp
);
  import ikf_pkg::*;

  localparam int MW   = DATA_W;          // magnitude width
  localparam int PW   = 2 * DATA_W;      // product width
  localparam int DIVN = DATA_W + FRAC_BITS;
  localparam int CW   = $clog2(DIVN + 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} st_t;

  st_t              st_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic             zero_r;
  logic             dzero_r;
  logic [MW-1:0]    ma_r;     // multiplicand / divisor
  logic [DIVN-1:0]  mb_r;     // multiplier bits / dividend bits
  logic [PW-1:0]    acc_r;    // product / quotient
  logic [MW:0]      rem_r;
  logic             over_r;
  fx_t              res_r;

  logic [MW-1:0] mag_a, mag_b;
  logic [MW+1:0] rem_sh;
  logic [PW-1:0] rnd;
  logic [PW-1:0] qv;
  logic          hi_nz;
  fx_t           fin;

  assign mag_a = req.a[DATA_W-1] ? MW'(-req.a) : MW'(req.a);
  assign mag_b = req.b[DATA_W-1] ? MW'(-req.b) : MW'(req.b);
  assign rem_sh = {rem_r, mb_r[DIVN-1]};

  always_comb begin
    rnd   = acc_r + (PW'(1) << (FRAC_BITS - 1));
    hi_nz = |(rnd >> (FRAC_BITS + DATA_W));
    qv    = st_r == S_MUL ? (rnd >> FRAC_BITS) : acc_r;
    // a zero numerator wins over a zero divisor
    if (zero_r) begin
      fin = '0;
    end else if (st_r == S_DIV && dzero_r) begin
      fin = neg_r ? SAT_MIN : SAT_MAX;
    end else if (neg_r) begin
      if (over_r || (st_r == S_MUL && hi_nz) || qv > PW'({1'b1, {(DATA_W-1){1'b0}}}))
        fin = SAT_MIN;
      else
        fin = fx_t'(-qv[DATA_W-1:0]);
    end else begin
      if (over_r || (st_r == S_MUL && hi_nz) || qv > PW'(SAT_MAX)) fin = SAT_MAX;
      else fin = qv[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (req.start) begin
            neg_r   <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
            acc_r   <= '0;
            rem_r   <= '0;
            over_r  <= 1'b0;
            if (req.op == OP_MUL) begin
              ma_r   <= mag_a;
              mb_r   <= DIVN'(mag_b);
              zero_r <= 1'b0;
              cnt_r  <= CW'(DATA_W);
              st_r   <= S_MUL;
            end else begin
              ma_r    <= mag_b;
              mb_r    <= {mag_a, {FRAC_BITS{1'b0}}};
              zero_r  <= req.a == '0;
              dzero_r <= req.b == '0;
              cnt_r   <= CW'(DIVN);
              st_r    <= S_DIV;
            end
          end
        end
        S_MUL: begin
          if (cnt_r == '0) begin
            res_r <= fin;
            st_r  <= S_DONE;
          end else begin
            // msb first: acc = 2*acc + a*bit
            acc_r <= (acc_r << 1) + (mb_r[DATA_W-1] ? PW'(ma_r) : PW'(0));
            mb_r  <= mb_r << 1;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_r == '0 || zero_r || dzero_r) begin
            res_r <= fin;
            st_r  <= S_DONE;
          end else begin
            mb_r  <= mb_r << 1;
            cnt_r <= cnt_r - 1'b1;
            if (rem_sh >= {2'b00, ma_r}) begin
              rem_r <= (MW+1)'(rem_sh - {2'b00, ma_r});
              if (cnt_r > CW'(DATA_W)) over_r <= 1'b1;
              acc_r <= (acc_r << 1) | PW'(1);
            end else begin
              rem_r <= rem_sh[MW:0];
              acc_r <= acc_r << 1;
            end
          end
        end
        S_DONE:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = st_r == S_DONE;
  assign rsp.res  = res_r;

  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("alu done held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |=> (st_r == S_MUL || st_r == S_DONE))
    else $error("alu mul left early");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> cnt_r <= CW'(DIVN))
    else $error("alu div count");
endmodule

// File: rtl/core/ikf_seq.sv
// sequencer: walks the filter update, at most one shared-unit operation per step
module ikf_seq #(
  parameter int FRAC_BITS = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ikf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ikf_pkg::REG_W-1:0]     cfg_data,
  ikf_in_if.sink                        in_ch,
  ikf_out_if.source                     out_ch,
  output ikf_pkg::alu_req_t             alu_req,
  input  ikf_pkg::alu_rsp_t             alu_rsp
);
  import ikf_pkg::*;

  localparam fx_t ONE_FX = fx_t'(1) <<< FRAC_BITS;
  localparam logic [REG_W-1:0] DT_RST = REG_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [REG_W-1:0] QA_RST = REG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [REG_W-1:0] QG_RST = REG_W'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [REG_W-1:0] RN_RST = REG_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [REG_W-1:0] C0_RST = REG_W'(64'd1 << FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_ANG, S_PD, S_P00, S_P01, S_P10, S_P11, S_PCT0, S_PCT1, S_E, S_K0, S_K1,
    S_T1, S_C0, S_C1, S_C2, S_C3, S_A, S_B, S_OUT
  } st_t;

  st_t  st_r;
  logic wait_r;      // operation issued, awaiting done
  logic [REG_W-1:0] dt_r, qa_r, qg_r, rn_r, c0_r;
  fx_t  ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  fx_t  am_r, gm_r, err_r, pd0_r, pd12_r;
  fx_t  pct0_r, pct1_r, k0_r, k1_r, t1_r, e_r;
  logic ov_r;
  fx_t  oa_r, or_r;
  fx_t  op_a, op_b;
  alu_op_t op_k;
  fx_t  dt_fx, c0_fx;
  fx_t  r;
  logic signed [DATA_W+1:0] pd0_sum;

  assign dt_fx = fx_t'({1'b0, dt_r});
  assign c0_fx = fx_t'($signed(c0_r));
  assign r     = alu_rsp.res;

  // exact three-term sum, clamped once
  assign pd0_sum = {{(DATA_W+2-REG_W){1'b0}}, qa_r}
                 - {{2{p01_r[DATA_W-1]}}, p01_r}
                 - {{2{p10_r[DATA_W-1]}}, p10_r};

  always_comb begin
    op_k = OP_MUL;
    op_a = '0;
    op_b = dt_fx;
    case (st_r)
      S_ANG:  op_a = fx_sub(gm_r, bias_r);
      S_P00:  op_a = pd0_r;
      S_P01:  op_a = pd12_r;
      S_P10:  op_a = pd12_r;
      S_P11:  op_a = fx_t'({1'b0, qg_r});
      S_PCT0: begin op_a = c0_fx; op_b = p00_r; end
      S_PCT1: begin op_a = c0_fx; op_b = p10_r; end
      S_E:    begin op_a = c0_fx; op_b = pct0_r; end
      S_K0:   begin op_k = OP_DIV; op_a = pct0_r; op_b = e_r; end
      S_K1:   begin op_k = OP_DIV; op_a = pct1_r; op_b = e_r; end
      S_T1:   begin op_a = c0_fx; op_b = p01_r; end
      S_C0:   begin op_a = k0_r; op_b = pct0_r; end
      S_C1:   begin op_a = k0_r; op_b = t1_r; end
      S_C2:   begin op_a = k1_r; op_b = pct0_r; end
      S_C3:   begin op_a = k1_r; op_b = t1_r; end
      S_A:    begin op_a = k0_r; op_b = err_r; end
      S_B:    begin op_a = k1_r; op_b = err_r; end
      default: ;
    endcase
  end

  assign alu_req.start = !wait_r && st_r != S_IDLE && st_r != S_OUT && st_r != S_PD;
  assign alu_req.op    = op_k;
  assign alu_req.a     = op_a;
  assign alu_req.b     = op_b;

  assign in_ch.ready      = st_r == S_IDLE;
  assign out_ch.valid     = ov_r;
  assign out_ch.angle_est = oa_r;
  assign out_ch.rate_est  = or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wait_r <= 1'b0;
      ov_r   <= 1'b0;
      dt_r <= DT_RST; qa_r <= QA_RST; qg_r <= QG_RST; rn_r <= RN_RST; c0_r <= C0_RST;
      ang_r <= '0; bias_r <= '0;
      p00_r <= ONE_FX; p01_r <= '0; p10_r <= '0; p11_r <= ONE_FX;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_SAMPLE_TIME:   dt_r <= cfg_data;
          REG_ANGLE_NOISE:   qa_r <= cfg_data;
          REG_BIAS_NOISE:    qg_r <= cfg_data;
          REG_MEASURE_NOISE: rn_r <= cfg_data;
          REG_OBSERVE_GAIN:  c0_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && st_r != S_OUT) ov_r <= 1'b0;
      if (alu_req.start) wait_r <= 1'b1;
      if (alu_rsp.done) wait_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          am_r <= fx_t'(in_ch.angle_meas) <<< FRAC_BITS;
          gm_r <= fx_t'(in_ch.rate_meas) <<< FRAC_BITS;
          st_r <= S_ANG;
        end
        S_ANG: if (alu_rsp.done) begin
          ang_r <= fx_add(ang_r, r);
          err_r <= fx_sub(am_r, fx_add(ang_r, r));
          st_r  <= S_PD;
        end
        S_PD: begin
          pd0_r  <= sat_sum(pd0_sum);
          pd12_r <= fx_sub('0, p11_r);
          st_r   <= S_P00;
        end
        S_P00: if (alu_rsp.done) begin p00_r <= fx_add(p00_r, r); st_r <= S_P01; end
        S_P01: if (alu_rsp.done) begin p01_r <= fx_add(p01_r, r); st_r <= S_P10; end
        S_P10: if (alu_rsp.done) begin p10_r <= fx_add(p10_r, r); st_r <= S_P11; end
        S_P11: if (alu_rsp.done) begin p11_r <= fx_add(p11_r, r); st_r <= S_PCT0; end
        S_PCT0: if (alu_rsp.done) begin pct0_r <= r; st_r <= S_PCT1; end
        S_PCT1: if (alu_rsp.done) begin pct1_r <= r; st_r <= S_E; end
        S_E: if (alu_rsp.done) begin e_r <= fx_add(fx_t'({1'b0, rn_r}), r); st_r <= S_K0; end
        S_K0: if (alu_rsp.done) begin k0_r <= r; st_r <= S_K1; end
        S_K1: if (alu_rsp.done) begin k1_r <= r; st_r <= S_T1; end
        S_T1: if (alu_rsp.done) begin t1_r <= r; st_r <= S_C0; end
        S_C0: if (alu_rsp.done) begin p00_r <= fx_sub(p00_r, r); st_r <= S_C1; end
        S_C1: if (alu_rsp.done) begin p01_r <= fx_sub(p01_r, r); st_r <= S_C2; end
        S_C2: if (alu_rsp.done) begin p10_r <= fx_sub(p10_r, r); st_r <= S_C3; end
        S_C3: if (alu_rsp.done) begin p11_r <= fx_sub(p11_r, r); st_r <= S_A; end
        S_A: if (alu_rsp.done) begin ang_r <= fx_add(ang_r, r); st_r <= S_B; end
        S_B: if (alu_rsp.done) begin bias_r <= fx_add(bias_r, r); st_r <= S_OUT; end
        // wait here while the previous result is still held
        S_OUT: if (!ov_r || out_ch.ready) begin
          oa_r <= ang_r;
          or_r <= fx_sub(gm_r, bias_r);
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_OUT)
    else $error("result without update");
  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |=> !alu_req.start)
    else $error("double issue");
endmodule

// File: rtl/core/imu_angle_kalman_filter_unit.sv
// channel | dir | beat contents
// in      | in  | angle_meas s16, rate_meas s16
// out     | out | angle_est s48 Q24.24, rate_est s48 Q24.24
// cfg     | in  | cfg_wr_en, cfg_idx 3b, cfg_data 32b, write only
// one beat takes 15 multiplies and two divides (a divide ends early when the
// numerator or the innovation variance is zero) on the one shared shift-add unit,
// plus three steps that use no unit operation: S_IDLE, S_PD and S_OUT
// in ready only while idle; a finished result waits for the held one to be taken
// synchronous active-low reset restores registers, state and identity covariance
module imu_angle_kalman_filter_unit #(
  parameter int FRAC_BITS = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ikf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ikf_pkg::REG_W-1:0]     cfg_data,
  ikf_in_if.sink                        in_ch,
  ikf_out_if.source                     out_ch
);
  import ikf_pkg::*;

  alu_req_t req;
  alu_rsp_t rsp;

  ikf_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk, .rst_n, .cfg_wr_en, .cfg_idx, .cfg_data,
    .in_ch, .out_ch, .alu_req(req), .alu_rsp(rsp)
  );

  ikf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk, .rst_n, .req, .rsp
  );
endmodule
